// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and helpers for the deduplicating event queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Number of queue slots (1 to 64).
    localparam int DEPTH   = 8;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int ID_W    = 16;
    localparam int STAT_W  = 8;
    localparam int WORD_W  = ID_W + STAT_W;
    localparam int OUT_W   = 3;

    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [OUT_W-1:0] OUT_STORED = 3'd0;
    localparam logic [OUT_W-1:0] OUT_DUP    = 3'd1;
    localparam logic [OUT_W-1:0] OUT_FULL   = 3'd2;
    localparam logic [OUT_W-1:0] OUT_POPPED = 3'd3;
    localparam logic [OUT_W-1:0] OUT_EMPTY  = 3'd4;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One result beat handed from the sequencer to the output register.
    typedef struct packed {
        logic [OUT_W-1:0]  outcome;
        logic [ID_W-1:0]   popped_event_id;
        logic [STAT_W-1:0] popped_status;
    } result_t;

    // Advance a slot pointer round the ring.
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== design/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter  int WIDTH = 24,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Queue sequencer: ring pointers, fill count, duplicate scan over the slot
// memory and pop, one input beat at a time.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [ID_W-1:0]   event_id,
    input  logic [STAT_W-1:0] event_status,
    output logic              res_valid,
    output result_t           res,
    input  logic              res_take
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_POP    = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]        state_reg,    state_next;
    ptr_t              head_reg,     head_next;
    ptr_t              tail_reg,     tail_next;
    ptr_t              scan_ptr_reg, scan_ptr_next;
    ptr_t              scan_idx_reg, scan_idx_next;
    cnt_t              count_reg,    count_next;
    logic [ID_W-1:0]   id_reg,       id_next;
    logic [STAT_W-1:0] stat_reg,     stat_next;
    result_t           res_reg,      res_next;

    logic              wr_en;
    ptr_t              wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    ptr_t              rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic              scan_last;
    logic              full;

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign scan_last = (CNT_W'(scan_idx_reg) == (count_reg - CNT_W'(1)));
    assign full      = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_idx_next = scan_idx_reg;
        count_next    = count_reg;
        id_next       = id_reg;
        stat_next     = stat_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = tail_reg;
        wr_data       = {id_reg, stat_reg};
        rd_en         = 1'b0;
        rd_addr       = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    id_next   = event_id;
                    stat_next = event_status;
                    if (opcode == OP_GET)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next   = '{OUT_EMPTY, '0, '0};
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_POP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // nothing to compare against: store straight away
                        wr_en      = 1'b1;
                        wr_data    = {event_id, event_status};
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + CNT_W'(1);
                        res_next   = '{OUT_STORED, '0, '0};
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        scan_ptr_next = ptr_inc(head_reg);
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_data[WORD_W-1 -: ID_W] == id_reg)
                begin
                    res_next   = '{OUT_DUP, '0, '0};
                    state_next = ST_RESULT;
                end
                else if (scan_last)
                begin
                    if (full)
                    begin
                        res_next = '{OUT_FULL, '0, '0};
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        tail_next  = ptr_inc(tail_reg);
                        count_next = count_reg + CNT_W'(1);
                        res_next   = '{OUT_STORED, '0, '0};
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_ptr_reg;
                    scan_ptr_next = ptr_inc(scan_ptr_reg);
                    scan_idx_next = scan_idx_reg + PTR_W'(1);
                end
            end

            ST_POP:
            begin
                res_next   = '{OUT_POPPED, rd_data[WORD_W-1 -: ID_W],
                               rd_data[STAT_W-1:0]};
                head_next  = ptr_inc(head_reg);
                count_next = count_reg - CNT_W'(1);
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            scan_ptr_reg <= '0;
            scan_idx_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            scan_ptr_reg <= scan_ptr_next;
            scan_idx_reg <= scan_idx_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        stat_reg <= stat_next;
        res_reg  <= res_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

endmodule

// ===== design/dedup_event_queue.sv =====
// ----------------------------------------------------------------------------
// dedup_event_queue
// Small first-in first-out queue of diagnostic events that drops duplicates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request per beat: a put
//   (opcode 0) of event_id with event_status, or a get (opcode 1). Each
//   request yields exactly one result beat on the output channel
//   (out_valid / out_stall): outcome, plus popped_event_id and popped_status
//   on a successful pop (zero otherwise).
//   Entries sit in a ring held in a one-read one-write slot memory; a put
//   reads the queued entries one per cycle and compares ids (a put to an
//   empty queue stores at once); a get reads the head entry from memory,
//   then forms its result. The result then moves into the output register,
//   so the next request is accepted while that beat waits downstream. The
//   memory read port sets the rate.
//   Reset clears the fill count and ring pointers: the queue starts empty at
//   once, with no clearing pass. Slot contents are not reset.
//   When the receiver stalls, the output beat holds; one more result may
//   finish inside the sequencer, after which in_stall stays high.
// ----------------------------------------------------------------------------
module dedup_event_queue
    import deq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [ID_W-1:0]   event_id,
    input  logic [STAT_W-1:0] event_status,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  outcome,
    output logic [ID_W-1:0]   popped_event_id,
    output logic [STAT_W-1:0] popped_status
);

    logic    res_valid;
    result_t res;
    logic    res_take;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg,       out_next;

    deq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .event_id     (event_id),
        .event_status (event_status),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take)
    );

    // Take a finished result whenever the output register is empty or its
    // beat leaves this cycle.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            // beat delivered, nothing to refill with
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset: hold while stalled, load on take.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid       = out_valid_reg;
    assign outcome         = out_reg.outcome;
    assign popped_event_id = out_reg.popped_event_id;
    assign popped_status   = out_reg.popped_status;

endmodule

// ===== design/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the deduplicating event queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
    import deq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [OUT_W-1:0]  outcome,
    input logic [ID_W-1:0]   popped_event_id,
    input logic [STAT_W-1:0] popped_status
);

    // A stalled output beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat withdrawn while stalled");

    // One request at a time: an accepted beat makes the block busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one in flight");

    // Only a pop carries entry data.
    a_zero_unless_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome != OUT_POPPED) |->
            (popped_event_id == '0) && (popped_status == '0))
        else $error("non-pop result carries entry data");

    // Outcome codes stay within the defined set.
    a_outcome_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome <= OUT_EMPTY))
        else $error("undefined outcome code");

endmodule

bind dedup_event_queue deq_checker u_deq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .outcome         (outcome),
    .popped_event_id (popped_event_id),
    .popped_status   (popped_status)
);

// ===== verif/tb_dedup_event_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dedup_event_queue
// Self-checking bench for the deduplicating diagnostic event queue.
// ----------------------------------------------------------------------------
// A shadow queue of id/status pairs predicts the outcome of every accepted
// put or get. Each beat that leaves the block is checked field by field
// against the oldest prediction. Stimulus opens with hand-picked corner
// cases, then runs random put/get traffic under four idling patterns: none,
// a sparse sender, a stalling receiver, and both at once.
// ----------------------------------------------------------------------------
module tb_dedup_event_queue;
    import deq_pkg::*;

    localparam int CLK_HALF    = 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MIX_ITEMS   = 132;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [STAT_W-1:0] status;
    } queued_event_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              opcode = OP_PUT;
    logic [ID_W-1:0]   event_id = '0;
    logic [STAT_W-1:0] event_status = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [OUT_W-1:0]  outcome;
    logic [ID_W-1:0]   popped_event_id;
    logic [STAT_W-1:0] popped_status;

    // Shadow of the queue contents, oldest entry at the front.
    queued_event_t shadow_queue[$];
    // Predicted result beats, oldest first.
    result_t       pending_results[$];

    int error_count    = 0;
    int cycle_count    = 0;
    int request_count  = 0;
    int outcome_tally[5];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    dedup_event_queue DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .event_id        (event_id),
        .event_status    (event_status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .outcome         (outcome),
        .popped_event_id (popped_event_id),
        .popped_status   (popped_status)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Watchdog: end the run if traffic stops making progress.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver back-pressure: redraw the stall at every falling edge.
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Work out the result of one accepted request and update the shadow queue.
    function automatic result_t predict_queue_op(input logic op,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [STAT_W-1:0] st);
        result_t       r;
        queued_event_t head;
        bit            seen;
        r    = '0;
        seen = 1'b0;
        if (op == OP_PUT)
        begin
            // The duplicate scan wins over the full check.
            foreach (shadow_queue[k])
            begin
                if (shadow_queue[k].id == id)
                begin
                    seen = 1'b1;
                end
            end
            if (seen)
            begin
                r.outcome = OUT_DUP;
            end
            else if (shadow_queue.size() >= DEPTH)
            begin
                r.outcome = OUT_FULL;
            end
            else
            begin
                shadow_queue.push_back('{id: id, status: st});
                r.outcome = OUT_STORED;
            end
        end
        else if (shadow_queue.size() == 0)
        begin
            r.outcome = OUT_EMPTY;
        end
        else
        begin
            head                = shadow_queue.pop_front();
            r.outcome           = OUT_POPPED;
            r.popped_event_id   = head.id;
            r.popped_status     = head.status;
        end
        return r;
    endfunction

    // Drive one request beat. Entered and left at a falling edge; valid stays
    // high straight into the next beat unless the sender chooses to idle.
    task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                                input logic [STAT_W-1:0] st);
        result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        event_id     <= id;
        event_status <= st;
        // Hold the beat until the block stops stalling.
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        r = predict_queue_op(op, id, st);
        pending_results.push_back(r);
        outcome_tally[r.outcome]++;
        request_count++;
        @(negedge clk);
    endtask

    // Check every result beat against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: outcome %0d id %h status %h",
                         $time, outcome, popped_event_id, popped_status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (outcome !== want.outcome)
                begin
                    $display("%0t: outcome mismatch: expected %0d, got %0d",
                             $time, want.outcome, outcome);
                    error_count++;
                end
                if (popped_event_id !== want.popped_event_id)
                begin
                    $display("%0t: popped_event_id mismatch: expected %h, got %h",
                             $time, want.popped_event_id, popped_event_id);
                    error_count++;
                end
                if (popped_status !== want.popped_status)
                begin
                    $display("%0t: popped_status mismatch: expected %h, got %h",
                             $time, want.popped_status, popped_status);
                    error_count++;
                end
            end
        end
    end

    // Pick an id: often one already queued, to provoke duplicates, sometimes
    // an edge value, otherwise anything at all.
    function automatic logic [ID_W-1:0] pick_event_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40 && shadow_queue.size() != 0)
        begin
            return shadow_queue[$urandom_range(0, shadow_queue.size() - 1)].id;
        end
        else if (roll < 50)
        begin
            return ($urandom_range(0, 1) == 1) ? {ID_W{1'b1}} : {ID_W{1'b0}};
        end
        return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endfunction

    // Random put/get traffic. Re-draw the put bias every few beats so the
    // queue swings between full and empty.
    task automatic run_random_mix(input int count);
        int put_pct;
        put_pct = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: put_pct = 20;
                    1: put_pct = 50;
                    2: put_pct = 75;
                    default: put_pct = 92;
                endcase
            end
            if ($urandom_range(0, 99) < put_pct)
            begin
                send_request(OP_PUT, pick_event_id(),
                             STAT_W'($urandom_range(0, (1 << STAT_W) - 1)));
            end
            else
            begin
                // Id and status are don't-care on a get: fill them with noise.
                send_request(OP_GET, ID_W'($urandom_range(0, (1 << ID_W) - 1)),
                             STAT_W'($urandom_range(0, (1 << STAT_W) - 1)));
            end
        end
    endtask

    // Corner cases: empty get, edge ids, duplicate with a new status, fill to
    // the brim, duplicate into a full queue, new id into a full queue, drain
    // past empty, and an id reused once its entry has left.
    task automatic test_directed_corners();
        send_request(OP_GET, 16'hFFFF, 8'hFF);
        send_request(OP_PUT, 16'hFFFF, 8'hFF);
        send_request(OP_PUT, 16'h0000, 8'h00);
        send_request(OP_PUT, 16'hFFFF, 8'h00);
        send_request(OP_PUT, 16'h0001, 8'h80);
        send_request(OP_PUT, 16'h8000, 8'h01);
        send_request(OP_PUT, 16'h5555, 8'hAA);
        send_request(OP_PUT, 16'hAAAA, 8'h55);
        send_request(OP_PUT, 16'h1234, 8'h7F);
        send_request(OP_PUT, 16'h00FF, 8'hFE);
        send_request(OP_PUT, 16'hFFFF, 8'h33);
        send_request(OP_PUT, 16'h4321, 8'hC3);
        for (int i = 0; i <= DEPTH; i++)
        begin
            send_request(OP_GET, 16'h0000, 8'h00);
        end
        send_request(OP_PUT, 16'hFFFF, 8'h3C);
        send_request(OP_GET, 16'hFFFF, 8'hFF);
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_mix(MIX_ITEMS);
    endtask

    task automatic test_sparse_sender();
        send_idle_pct  = 75;
        recv_stall_pct = 0;
        run_random_mix(MIX_ITEMS);
    endtask

    task automatic test_stalled_receiver();
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        run_random_mix(MIX_ITEMS);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        run_random_mix(MIX_ITEMS);
    endtask

    initial
    begin
        foreach (outcome_tally[k])
        begin
            outcome_tally[k] = 0;
        end
        // Hold reset, then release it at a falling edge.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_corners();
        test_back_to_back();
        test_sparse_sender();
        test_stalled_receiver();
        test_mixed_idling();

        in_valid <= 1'b0;
        // Drain outstanding results, then watch a while for stray beats.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DEPTH + 8) @(posedge clk);

        $display("Sent %0d requests: %0d stored, %0d duplicate drops, %0d full drops,",
                 request_count, outcome_tally[OUT_STORED], outcome_tally[OUT_DUP],
                 outcome_tally[OUT_FULL]);
        $display("%0d pops and %0d empty gets, with and without idling on both sides.",
                 outcome_tally[OUT_POPPED], outcome_tally[OUT_EMPTY]);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/deq_pkg.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/dedup_event_queue.sv
design/deq_checker.sv
verif/tb_dedup_event_queue.sv
